/* src/dwarf_abbrev_table_indexer_core_macros.svh */
// Assertion macros shared by the abbreviation table indexer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DWARF_ABBREV_TABLE_INDEXER_CORE_MACROS_SVH
`define DWARF_ABBREV_TABLE_INDEXER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DATI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DATI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dati_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the abbreviation table indexer.
// No dependencies; every other file of the block except the macros header uses this package.
package dati_pkg;

    // Default number of store entries (codes 0 .. DEFAULT_MAX_CODES-1).
    localparam int DEFAULT_MAX_CODES = 1024;

    // Field widths.
    localparam int GEN_W  = 8;
    localparam int WORD_W = 32;

    // Depth of the result queue in front of the output port.
    localparam int OUT_FIFO_DEPTH = 4;

    // Result kinds.
    localparam logic [1:0] KIND_ENTRY    = 2'd0;
    localparam logic [1:0] KIND_ZERO_END = 2'd1;
    localparam logic [1:0] KIND_SECT_END = 2'd2;

    // One store entry: valid flag, table generation and recorded position.
    typedef struct packed {
        logic              valid;
        logic [GEN_W-1:0]  gen;
        logic [WORD_W-1:0] pos;
    } dati_entry_t;

    localparam int ENTRY_W = $bits(dati_entry_t);

    // A result in flight from the parser to the store stage.
    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] pos;
        logic [1:0]        kind;
        logic              ovf;
        logic [WORD_W-1:0] highest;
        logic              done;
        logic              lookup;
        logic [GEN_W-1:0]  gen;
    } dati_item_t;

    // A finished result as it leaves the block.
    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic [WORD_W-1:0] pos;
        logic [1:0]        kind;
        logic              first;
        logic              ovf;
        logic [WORD_W-1:0] highest;
        logic              done;
    } dati_result_t;

    localparam int RESULT_W = $bits(dati_result_t);

    // Status of the store clearing pass.
    typedef struct packed {
        logic sweeping;
        logic wrap_cleared;
    } dati_sweep_t;

endpackage

/* src/dwarf_abbrev_table_indexer_core.sv */
`timescale 1ns / 1ps
// Top level of the abbreviation table indexer.
// Depends on dati_pkg, dati_parser, dati_store, dati_out_fifo and the macros header.
`include "dwarf_abbrev_table_indexer_core_macros.svh"

// The indexer takes one byte of a DWARF abbreviation table per cycle while in_ready is
// high and gives a result for every completed abbreviation code and at the end of the
// table, registered in stage 1 and then in the result queue. The rate of one byte per
// cycle is held by the position store, a single RAM with one read and one write port:
// a code is read as its last byte arrives and written back in the next cycle, with the
// write forwarded to a lookup of the same entry in the next cycle. A result queue of
// four entries lets bytes keep flowing while results wait at the output. After reset
// all MAX_CODES store entries (1024 by default) are cleared before the first byte is
// taken; the same pass, after any results in flight have reached the queue, runs before
// the restart byte of every 256th table, when the generation tag wraps to zero.
module dwarf_abbrev_table_indexer_core #(
    parameter int MAX_CODES = dati_pkg::DEFAULT_MAX_CODES
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input bytes.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        section_end,
    input  logic        table_restart,
    // Results.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] abbrev_code,
    output logic [31:0] entry_position,
    output logic [1:0]  result_kind,
    output logic        first_seen,
    output logic        code_overflow,
    output logic [31:0] highest_code,
    output logic        table_done,
    // Configuration: table base position.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import dati_pkg::*;

    localparam int FCW = $clog2(OUT_FIFO_DEPTH + 1);

    logic [31:0]    table_base_reg;
    logic           in_accept;
    logic           item_emit;
    dati_item_t     item;
    logic [7:0]     gen;
    logic           res_valid;
    dati_result_t   res;
    dati_sweep_t    sweep;
    dati_result_t   head;
    logic [FCW-1:0] fifo_count;
    logic           credit_ok;
    logic           wrap_pending;

    // Configuration register; the user must write it only while the block is idle, as the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_base_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Input flow control: room in the queue for the result in stage 1 and two more.
    always_comb
    begin
        credit_ok    = (32'(fifo_count) + 32'(res_valid)) <= 32'(OUT_FIFO_DEPTH - 2);
        wrap_pending = table_restart && gen == '1 && !sweep.wrap_cleared;
        in_ready     = !sweep.sweeping && credit_ok && !wrap_pending;
        in_accept    = in_valid && in_ready;
    end

    dati_parser #(
        .MAX_CODES (MAX_CODES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (data_byte),
        .section_end   (section_end),
        .table_restart (table_restart),
        .table_base    (table_base_reg),
        .item_emit     (item_emit),
        .item          (item),
        .gen           (gen)
    );

    dati_store #(
        .MAX_CODES (MAX_CODES)
    ) u_store (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (in_accept && item_emit),
        .req            (item),
        .wrap_request   (in_valid && wrap_pending),
        .restart_accept (in_accept && table_restart),
        .res_valid      (res_valid),
        .res            (res),
        .sweep          (sweep)
    );

    dati_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (out_ready),
        .head_valid (out_valid),
        .head       (head),
        .count      (fifo_count)
    );

    assign abbrev_code    = head.code;
    assign entry_position = head.pos;
    assign result_kind    = head.kind;
    assign first_seen     = head.first;
    assign code_overflow  = head.ovf;
    assign highest_code   = head.highest;
    assign table_done     = head.done;

    // No byte is taken while the store is being cleared.
    `DATI_ASSERT_IMP(a_no_accept_in_sweep, sweep.sweeping, !in_ready, "byte accepted during clear")
    // The credit check keeps the result queue from overflowing.
    `DATI_ASSERT_IMP(a_fifo_no_overflow, res_valid, 32'(fifo_count) < 32'(OUT_FIFO_DEPTH), "result queue overflow")
    // A newly stored code is always an in-range entry code.
    `DATI_ASSERT_IMP(a_first_is_entry, out_valid && first_seen, result_kind == KIND_ENTRY && !code_overflow, "first_seen on a result that cannot be stored")
    // Every end-of-table kind closes the table.
    `DATI_ASSERT_IMP(a_end_kind_done, out_valid && result_kind != KIND_ENTRY, table_done, "end result without table_done")
    // A wrap clear starts as soon as no store write is still in flight.
    `DATI_ASSERT_NXT(a_sweep_start_drained, !sweep.sweeping && !res_valid && in_valid && wrap_pending, sweep.sweeping, "wrap clear did not start")

endmodule

/* src/dati_ram.sv */
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// Depends on dati_pkg for its default sizes only.
module dati_ram #(
    parameter int WIDTH = dati_pkg::ENTRY_W,
    parameter int DEPTH = dati_pkg::DEFAULT_MAX_CODES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port returns the old contents when both ports hit one address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/dati_parser.sv */
`timescale 1ns / 1ps
// Byte-level parser: walks the ULEB128 fields of each abbreviation entry.
// Depends on dati_pkg for the item type and result kinds.
module dati_parser #(
    parameter int MAX_CODES = dati_pkg::DEFAULT_MAX_CODES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 section_end,
    input  logic                 table_restart,
    input  logic [31:0]          table_base,
    output logic                 item_emit,
    output dati_pkg::dati_item_t item,
    output logic [7:0]           gen
);
    import dati_pkg::*;

    // Parse phase codes.
    localparam logic [2:0] PH_CODE  = 3'd0;
    localparam logic [2:0] PH_TAG   = 3'd1;
    localparam logic [2:0] PH_CHILD = 3'd2;
    localparam logic [2:0] PH_ATTR  = 3'd3;
    localparam logic [2:0] PH_FORM  = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [5:0] LEB_STEP      = 6'd7;
    localparam logic [5:0] LEB_SHIFT_MAX = 6'd56;
    localparam logic [5:0] LEB_SHIFT_SAT = 6'd32;

    logic [2:0]        phase_reg, phase_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [5:0]        shift_reg, shift_next;
    logic              attr_nz_reg, attr_nz_next;
    logic [WORD_W-1:0] offset_reg, offset_next;
    logic [WORD_W-1:0] max_reg, max_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;

    // State as seen by this byte, after a restart has been applied.
    logic [2:0]        ph;
    logic [WORD_W-1:0] acc, off, mx;
    logic [5:0]        sh;
    logic              anz;
    logic [GEN_W-1:0]  gen_e;

    logic              more;
    logic [6:0]        payload;
    logic [63:0]       wide;
    logic [WORD_W-1:0] acc_upd;
    logic [5:0]        sh_upd;

    logic [2:0]        nph;
    logic [WORD_W-1:0] nacc, noff, nmx;
    logic [5:0]        nsh;
    logic              nanz;
    logic              emit;
    dati_item_t        it;

    always_comb
    begin
        // A restart byte starts a fresh table before it is parsed.
        ph    = table_restart ? PH_CODE : phase_reg;
        acc   = table_restart ? '0 : acc_reg;
        sh    = table_restart ? '0 : shift_reg;
        anz   = table_restart ? 1'b0 : attr_nz_reg;
        off   = table_restart ? '0 : offset_reg;
        mx    = table_restart ? '0 : max_reg;
        gen_e = table_restart ? gen_reg + 1'b1 : gen_reg;

        more    = data_byte[7];
        payload = data_byte[6:0];

        // ULEB128 accumulation with saturation past 32 bits.
        wide = 64'(payload) << sh;
        if (payload == '0)
        begin
            acc_upd = acc;
        end
        else if (sh >= LEB_SHIFT_SAT || wide[63:32] != '0)
        begin
            acc_upd = '1;
        end
        else
        begin
            acc_upd = acc | wide[31:0];
        end
        sh_upd = (sh < LEB_SHIFT_MAX) ? sh + LEB_STEP : sh;

        nph  = ph;
        nacc = acc;
        nsh  = sh;
        nanz = anz;
        nmx  = mx;
        noff = (ph == PH_DONE) ? off : off + 1'b1;
        emit = 1'b0;

        it         = '0;
        it.pos     = table_base + off + 1'b1;
        it.kind    = KIND_ENTRY;
        it.gen     = gen_e;

        case (ph)
            PH_CODE:
            begin
                nacc = acc_upd;
                nsh  = sh_upd;
                if (!more)
                begin
                    it.code = acc_upd;
                    nacc    = '0;
                    nsh     = '0;
                    emit    = 1'b1;
                    if (acc_upd == '0)
                    begin
                        it.kind = KIND_ZERO_END;
                        it.done = 1'b1;
                        nph     = PH_DONE;
                    end
                    else
                    begin
                        if (acc_upd > mx)
                        begin
                            nmx = acc_upd;
                        end
                        if (acc_upd >= 32'(MAX_CODES))
                        begin
                            it.ovf = 1'b1;
                        end
                        else
                        begin
                            it.lookup = 1'b1;
                        end
                        nph = PH_TAG;
                        if (section_end)
                        begin
                            it.done = 1'b1;
                            nph     = PH_DONE;
                        end
                    end
                end
            end
            PH_TAG:
            begin
                if (!more)
                begin
                    nph = PH_CHILD;
                end
            end
            PH_CHILD:
            begin
                nanz = 1'b0;
                nph  = PH_ATTR;
            end
            PH_ATTR:
            begin
                if (payload != '0)
                begin
                    nanz = 1'b1;
                end
                if (!more)
                begin
                    nph = PH_FORM;
                end
            end
            PH_DONE:
            begin
                nph = PH_DONE;
            end
            default:
            begin
                // Form field; a zero attribute closes the entry.
                if (!more)
                begin
                    if (anz)
                    begin
                        nanz = 1'b0;
                        nph  = PH_ATTR;
                    end
                    else
                    begin
                        nph = PH_CODE;
                    end
                end
            end
        endcase

        // The last section byte ends the table wherever it falls.
        if (ph != PH_DONE && !emit && section_end)
        begin
            emit    = 1'b1;
            it.code = '0;
            it.kind = KIND_SECT_END;
            it.done = 1'b1;
            nph     = PH_DONE;
        end
        it.highest = nmx;

        phase_next   = accept ? nph  : phase_reg;
        acc_next     = accept ? nacc : acc_reg;
        shift_next   = accept ? nsh  : shift_reg;
        attr_nz_next = accept ? nanz : attr_nz_reg;
        offset_next  = accept ? noff : offset_reg;
        max_next     = accept ? nmx  : max_reg;
        gen_next     = accept ? gen_e : gen_reg;
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CODE;
            acc_reg     <= '0;
            shift_reg   <= '0;
            attr_nz_reg <= 1'b0;
            offset_reg  <= '0;
            max_reg     <= '0;
            gen_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            shift_reg   <= shift_next;
            attr_nz_reg <= attr_nz_next;
            offset_reg  <= offset_next;
            max_reg     <= max_next;
            gen_reg     <= gen_next;
        end
    end

    assign item_emit = emit;
    assign item      = it;
    assign gen       = gen_reg;

endmodule

/* src/dati_store.sv */
`timescale 1ns / 1ps
// Position store: lookup, first-seen decision and write-back, plus the clearing pass.
// Depends on dati_pkg and dati_ram.
module dati_store #(
    parameter int MAX_CODES = dati_pkg::DEFAULT_MAX_CODES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  dati_pkg::dati_item_t   req,
    input  logic                   wrap_request,
    input  logic                   restart_accept,
    output logic                   res_valid,
    output dati_pkg::dati_result_t res,
    output dati_pkg::dati_sweep_t  sweep
);
    import dati_pkg::*;

    localparam int AW = $clog2(MAX_CODES);

    logic              s1_valid_reg;
    dati_item_t        s1_item_reg;
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    dati_entry_t       fwd_entry_reg;
    logic              sweep_reg, sweep_next;
    logic [AW-1:0]     sweep_addr_reg, sweep_addr_next;
    logic              wrap_done_reg, wrap_done_next;

    logic [ENTRY_W-1:0] ram_rd_data;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;

    logic [AW-1:0]      s1_addr;
    dati_entry_t        cur_entry;
    logic               hit;
    logic               s1_write;
    dati_entry_t        new_entry;

    // Read the entry as the item arrives; the data returns with the item in stage 1.
    dati_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CODES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (req_valid && req.lookup),
        .rd_addr (req.code[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Stage 1: take the write of the previous cycle when it hit the same entry.
    always_comb
    begin
        s1_addr   = s1_item_reg.code[AW-1:0];
        cur_entry = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_entry_reg
                                                               : dati_entry_t'(ram_rd_data);
        hit       = cur_entry.valid && cur_entry.gen == s1_item_reg.gen;
        s1_write  = s1_valid_reg && s1_item_reg.lookup && !hit;

        new_entry.valid = 1'b1;
        new_entry.gen   = s1_item_reg.gen;
        new_entry.pos   = s1_item_reg.pos;
    end

    // The write port serves the clearing pass or the stage 1 write, never both.
    always_comb
    begin
        if (sweep_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = s1_write;
            ram_wr_addr = s1_addr;
            ram_wr_data = new_entry;
        end
    end

    // Clearing pass: after reset, and before the table whose generation wraps to zero.
    always_comb
    begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        wrap_done_next  = wrap_done_reg;
        if (sweep_reg)
        begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == AW'(MAX_CODES - 1))
            begin
                sweep_next      = 1'b0;
                sweep_addr_next = '0;
            end
        end
        else if (wrap_request && !wrap_done_reg && !s1_valid_reg)
        begin
            sweep_next     = 1'b1;
            wrap_done_next = 1'b1;
        end
        else if (restart_accept)
        begin
            wrap_done_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            wrap_done_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= req_valid;
            fwd_valid_reg  <= s1_write;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            wrap_done_reg  <= wrap_done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s1_item_reg <= req;
        end
        fwd_addr_reg  <= s1_addr;
        fwd_entry_reg <= new_entry;
    end

    always_comb
    begin
        res.code    = s1_item_reg.code;
        res.pos     = s1_item_reg.pos;
        res.kind    = s1_item_reg.kind;
        res.first   = s1_item_reg.lookup && !hit;
        res.ovf     = s1_item_reg.ovf;
        res.highest = s1_item_reg.highest;
        res.done    = s1_item_reg.done;
    end

    assign res_valid          = s1_valid_reg;
    assign sweep.sweeping     = sweep_reg;
    assign sweep.wrap_cleared = wrap_done_reg;

endmodule

/* src/dati_out_fifo.sv */
`timescale 1ns / 1ps
// Small result queue that decouples the store stage from the output port.
// Depends on dati_pkg for the result type.
module dati_out_fifo #(
    parameter int DEPTH = dati_pkg::OUT_FIFO_DEPTH,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dati_pkg::dati_result_t push_data,
    input  logic                   pop,
    output logic                   head_valid,
    output dati_pkg::dati_result_t head,
    output logic [CW-1:0]          count
);
    import dati_pkg::*;

    dati_result_t  entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    // Pointer and fill count update.
    always_comb
    begin
        do_pop      = pop && count_reg != '0;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = entries[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* tb/sv/abbrev_index_checker.sv */
`timescale 1ns / 1ps
// Result checker for the abbreviation table indexer: follows the byte, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on dati_pkg for the result type and the result kind codes.
module abbrev_index_checker #(
    parameter int MAX_CODES = dati_pkg::DEFAULT_MAX_CODES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        section_end,
    input  logic        table_restart,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] abbrev_code,
    input  logic [31:0] entry_position,
    input  logic [1:0]  result_kind,
    input  logic        first_seen,
    input  logic        code_overflow,
    input  logic [31:0] highest_code,
    input  logic        table_done,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [2:0] {
        PH_CODE,
        PH_TAG,
        PH_CHILD,
        PH_ATTR,
        PH_FORM,
        PH_DONE
    } parse_phase_e;

    // Shadow copy of the parser state and the code store.
    parse_phase_e phase;
    logic [31:0]  base_pos;
    logic [31:0]  code_acc;
    logic [5:0]   leb_shift;
    logic         attr_nz;
    logic [31:0]  byte_off;
    logic [31:0]  max_code;
    logic [7:0]   table_gen;
    logic         slot_valid [MAX_CODES];
    logic [7:0]   slot_gen [MAX_CODES];

    // Results still owed by the block, oldest first.
    dati_pkg::dati_result_t code_results_q[$];

    function void begin_table();
        phase = PH_CODE;
        code_acc = '0;
        leb_shift = '0;
        attr_nz = 1'b0;
        byte_off = '0;
        max_code = '0;
    endfunction

    function void clear_predictor();
        base_pos = '0;
        table_gen = '0;
        for (int i = 0; i < MAX_CODES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_gen[i] = '0;
        end
        begin_table();
        code_results_q.delete();
        fail_count = 0;
        pending = 0;
    endfunction

    // One ULEB128 group into the code; values past 32 bits saturate.
    function void leb_add(input logic [6:0] payload);
        logic [31:0] wide;
        wide = {25'd0, payload};
        if (payload != 7'd0)
        begin
            if (leb_shift >= 32)
                code_acc = '1;
            else if (leb_shift > 25 && (wide >> (32 - leb_shift)) != 0)
                code_acc = '1;
            else
                code_acc = code_acc | (wide << leb_shift);
        end
        if (leb_shift < 56)
            leb_shift = leb_shift + 6'd7;
    endfunction

    // Advances the shadow parser by one byte and queues the result it causes.
    function void index_abbrev_byte(input logic [7:0] b, input logic se, input logic rs);
        logic                   more;
        logic [6:0]             payload;
        logic [31:0]            pos;
        logic                   emit;
        dati_pkg::dati_result_t r;
        more = b[7];
        payload = b[6:0];
        emit = 1'b0;
        r = '0;

        // A restart bumps the generation; a wrap to zero drops every entry.
        if (rs)
        begin
            table_gen = table_gen + 8'd1;
            if (table_gen == 8'd0)
                for (int i = 0; i < MAX_CODES; i++)
                    slot_valid[i] = 1'b0;
            begin_table();
        end
        if (phase == PH_DONE)
            return;

        pos = base_pos + byte_off + 32'd1;
        byte_off = byte_off + 32'd1;

        case (phase)
            PH_CODE:
            begin
                leb_add(payload);
                if (!more)
                begin
                    r.code = code_acc;
                    code_acc = '0;
                    leb_shift = '0;
                    emit = 1'b1;
                    if (r.code == 32'd0)
                    begin
                        r.kind = dati_pkg::KIND_ZERO_END;
                        r.done = 1'b1;
                        phase = PH_DONE;
                    end
                    else
                    begin
                        r.kind = dati_pkg::KIND_ENTRY;
                        if (r.code > max_code)
                            max_code = r.code;
                        if (r.code >= MAX_CODES)
                            r.ovf = 1'b1;
                        else if (!slot_valid[r.code] || slot_gen[r.code] != table_gen)
                        begin
                            slot_valid[r.code] = 1'b1;
                            slot_gen[r.code] = table_gen;
                            r.first = 1'b1;
                        end
                        phase = PH_TAG;
                        if (se)
                        begin
                            r.done = 1'b1;
                            phase = PH_DONE;
                        end
                    end
                end
            end
            PH_TAG:
            begin
                if (!more)
                    phase = PH_CHILD;
            end
            PH_CHILD:
            begin
                attr_nz = 1'b0;
                phase = PH_ATTR;
            end
            PH_ATTR:
            begin
                if (payload != 7'd0)
                    attr_nz = 1'b1;
                if (!more)
                    phase = PH_FORM;
            end
            default:
            begin
                // End of a form: a zero attribute closes the entry.
                if (!more)
                begin
                    if (attr_nz)
                    begin
                        attr_nz = 1'b0;
                        phase = PH_ATTR;
                    end
                    else
                        phase = PH_CODE;
                end
            end
        endcase

        // The last section byte ends the table wherever the parser stands.
        if (!emit && se)
        begin
            emit = 1'b1;
            r.code = '0;
            r.kind = dati_pkg::KIND_SECT_END;
            r.done = 1'b1;
            phase = PH_DONE;
        end
        if (emit)
        begin
            r.pos = pos;
            r.highest = max_code;
            code_results_q.push_back(r);
        end
    endfunction

    function void check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    initial clear_predictor();

    // Every transaction is taken at the rising edge, before the block updates.
    always @(posedge clk or negedge rst_n)
    begin : watch
        dati_pkg::dati_result_t want;
        if (!rst_n)
            clear_predictor();
        else
        begin
            if (cfg_valid && cfg_ready)
                base_pos = cfg_data;
            if (in_valid && in_ready)
                index_abbrev_byte(data_byte, section_end, table_restart);
            if (out_valid && out_ready)
            begin
                if (code_results_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual code 0x%08h kind %0d",
                             $time, abbrev_code, result_kind);
                end
                else
                begin
                    want = code_results_q.pop_front();
                    check_field("abbrev_code", want.code, abbrev_code);
                    check_field("entry_position", want.pos, entry_position);
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("first_seen", 32'(want.first), 32'(first_seen));
                    check_field("code_overflow", 32'(want.ovf), 32'(code_overflow));
                    check_field("highest_code", want.highest, highest_code);
                    check_field("table_done", 32'(want.done), 32'(table_done));
                end
            end
            pending = code_results_q.size();
        end
    end

endmodule

/* tb/sv/dwarf_abbrev_table_indexer_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the abbreviation table indexer: drives tables of bytes and
// the base register, and gives the verdict from the checker's failure count.
// Depends on dati_pkg, the indexer RTL and abbrev_index_checker.
module dwarf_abbrev_table_indexer_core_tb;

    localparam int MAX_CODES    = dati_pkg::DEFAULT_MAX_CODES;
    localparam int QUIET_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        section_end = 1'b0;
    logic        table_restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] abbrev_code;
    logic [31:0] entry_position;
    logic [1:0]  result_kind;
    logic        first_seen;
    logic        code_overflow;
    logic [31:0] highest_code;
    logic        table_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    // Bytes of the table being built.
    logic [7:0] tbl_q[$];

    dwarf_abbrev_table_indexer_core #(.MAX_CODES(MAX_CODES)) dut (.*);

    abbrev_index_checker #(.MAX_CODES(MAX_CODES)) u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result back-pressure, redrawn every cycle.
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one byte after a random idle gap and waits for its transaction.
    task automatic send_item(input logic [7:0] b, input logic se, input logic rs);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        section_end <= se;
        table_restart <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the input until every owed result is out, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function void push_byte(input logic [7:0] b);
        tbl_q.push_back(b);
    endfunction

    // ULEB128 with optional padding groups of zero payload.
    function void push_leb(input logic [31:0] v, input int pad);
        logic [31:0] rest;
        logic [7:0]  b;
        rest = v;
        do
        begin
            b = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (rest != 0 || pad > 0)
                b[7] = 1'b1;
            push_byte(b);
        end
        while (rest != 0);
        for (int i = pad; i > 0; i--)
            push_byte((i > 1) ? 8'h80 : 8'h00);
    endfunction

    // A code longer than 32 bits of payload.
    function void push_oversized();
        int n;
        n = $urandom_range(5, 8);
        for (int i = 0; i < n - 1; i++)
            push_byte({1'b1, 7'($urandom)});
        push_byte({1'b0, 7'($urandom_range(1, 127))});
    endfunction

    // Small codes repeat often; the store limits and the top of the range show up.
    function logic [31:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 12);
        else if (r < 58)
            return MAX_CODES - 1;
        else if (r < 66)
            return MAX_CODES + $urandom_range(0, 3);
        else if (r < 80)
            return $urandom_range(13, MAX_CODES - 2);
        else if (r < 92)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    // Code, tag, child byte, attribute and form pairs, zero pair.
    function void push_entry();
        if ($urandom_range(0, 9) == 0)
            push_oversized();
        else
            push_leb(pick_code(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
        push_leb($urandom_range(1, 300), 0);
        push_byte(8'($urandom));
        repeat ($urandom_range(0, 3))
        begin
            push_leb($urandom_range(1, 16383), 0);
            push_leb($urandom_range(1, 40), 0);
        end
        push_leb(32'd0, ($urandom_range(0, 3) == 0) ? 1 : 0);
        push_leb(($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0, 0);
    endfunction

    // Random tables, mostly well formed, some cut short or left open.
    task automatic run_tables(input int min_bytes, input int min_tables, input int pause_at);
        int   bytes_sent;
        int   tables;
        int   mode;
        int   cut;
        logic se_last;
        logic rs_first;
        logic open_now;
        logic open_prev;
        bytes_sent = 0;
        tables = 0;
        open_prev = 1'b0;
        while (bytes_sent < min_bytes || tables < min_tables)
        begin
            tbl_q.delete();
            se_last = 1'b0;
            open_now = 1'b0;
            mode = $urandom_range(0, 99);
            if (mode < 35)
                push_leb(32'd0, ($urandom_range(0, 4) == 0) ? 1 : 0);
            else if (mode < 40)
            begin
                push_byte(8'($urandom));
                se_last = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 3)) push_entry();
                mode = $urandom_range(0, 9);
                if (mode < 5)
                    push_leb(32'd0, 0);
                else if (mode < 7)
                    se_last = 1'b1;
                else if (mode < 9)
                begin
                    cut = $urandom_range(1, tbl_q.size());
                    while (tbl_q.size() > cut)
                        void'(tbl_q.pop_back());
                    se_last = 1'b1;
                end
                else
                    open_now = 1'b1;
            end

            // An open table may simply carry on with more entries.
            rs_first = !(open_prev && $urandom_range(0, 1) == 1);
            foreach (tbl_q[i])
                send_item(tbl_q[i], se_last && i == tbl_q.size() - 1, rs_first && i == 0);
            bytes_sent += tbl_q.size();
            if (rs_first)
                tables++;
            open_prev = open_now;

            // Bytes after a finished table, which the block must ignore.
            if (!open_now && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) send_item(8'($urandom), 1'b0, 1'b0);

            if (pause_at > 0 && bytes_sent >= pause_at)
            begin
                drain();
                pause_at = 0;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_base(32'h0000_1000);

        // Directed: bytes before any restart, an entry with a padded zero
        // attribute, a repeated code and the zero code end.
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'h11, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'h83, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h08, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        // A byte after the table end, without restart.
        send_item(8'hAA, 1'b0, 1'b0);
        // Saturated code, then the section ends in the middle of the tag.
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        // Code equal to the store size, ending on the last section byte.
        send_item(8'h80, 1'b0, 1'b1);
        send_item(8'h08, 1'b1, 1'b0);
        // The first code again, stored anew in a fresh table.
        send_item(8'h7F, 1'b1, 1'b1);

        // Single byte tables until the generation comes round to the one that
        // stored the code above; the wrap must have dropped that entry.
        repeat (255) send_item(8'h05, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b1);

        // Random phases with different idling and base settings.
        drain();
        write_base(32'hFFFF_FFF8);
        idle_pct = 0;
        stall_pct = 0;
        run_tables(270, 16, 135);

        drain();
        write_base(32'h0000_0000);
        idle_pct = 81;
        stall_pct = 0;
        run_tables(270, 16, 0);

        drain();
        write_base($urandom);
        idle_pct = 0;
        stall_pct = 81;
        run_tables(270, 16, 0);

        drain();
        write_base(32'hFFFF_FFFF);
        idle_pct = 33;
        stall_pct = 33;
        run_tables(270, 16, 0);

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
